### rtl/taa_pkg.sv
// Shared types, register map and reset constants of the touch alertness alarm.
`default_nettype none
package taa_pkg;

	localparam int WINDOW_DEF = 10;
	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 32;
	localparam int DATA_W     = 32;
	localparam int APB_ADDR_W = 5;

	localparam logic        RST_SENSOR_ENABLE   = 1'b1;
	localparam logic [15:0] RST_LEVEL_THRESHOLD = 16'd20;
	localparam logic [31:0] RST_STAGE_TWO_MS    = 32'd5000;
	localparam logic [31:0] RST_STAGE_THREE_MS  = 32'd10000;
	localparam logic [31:0] RST_PERIOD_ONE_MS   = 32'd1000;
	localparam logic [31:0] RST_PERIOD_TWO_MS   = 32'd500;
	localparam logic [31:0] RST_PERIOD_THREE_MS = 32'd250;

	typedef enum logic [2:0] {
		REG_SENSOR_ENABLE,
		REG_LEVEL_THRESHOLD,
		REG_STAGE_TWO_MS,
		REG_STAGE_THREE_MS,
		REG_PERIOD_ONE_MS,
		REG_PERIOD_TWO_MS,
		REG_PERIOD_THREE_MS
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAGE_IDLE,
		STAGE_SLOW,
		STAGE_MEDIUM,
		STAGE_FAST
	} stage_t;

	typedef struct packed {
		logic                  sensor_enable;
		logic [SAMPLE_W-1:0]   level_threshold;
		logic [TIME_W-1:0]     stage_two_ms;
		logic [TIME_W-1:0]     stage_three_ms;
		logic [TIME_W-1:0]     period_one_ms;
		logic [TIME_W-1:0]     period_two_ms;
		logic [TIME_W-1:0]     period_three_ms;
	} cfg_t;

	// Per-word side information that travels down the pipeline.
	typedef struct packed {
		logic              en;
		logic [TIME_W-1:0] now_ms;
	} tick_info_t;

endpackage
`default_nettype wire

### rtl/taa_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module taa_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [taa_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [taa_pkg::DATA_W-1:0]       pwdata,
	output logic      [taa_pkg::DATA_W-1:0]       prdata,
	output logic                                  pready,
	output taa_pkg::cfg_t                         cfg
);

	taa_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[taa_pkg::APB_ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enable   <= taa_pkg::RST_SENSOR_ENABLE;
			cfg_q.level_threshold <= taa_pkg::RST_LEVEL_THRESHOLD;
			cfg_q.stage_two_ms    <= taa_pkg::RST_STAGE_TWO_MS;
			cfg_q.stage_three_ms  <= taa_pkg::RST_STAGE_THREE_MS;
			cfg_q.period_one_ms   <= taa_pkg::RST_PERIOD_ONE_MS;
			cfg_q.period_two_ms   <= taa_pkg::RST_PERIOD_TWO_MS;
			cfg_q.period_three_ms <= taa_pkg::RST_PERIOD_THREE_MS;
		end else if (wr) begin
			unique case (idx)
				taa_pkg::REG_SENSOR_ENABLE:   cfg_q.sensor_enable   <= pwdata[0];
				taa_pkg::REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= pwdata[15:0];
				taa_pkg::REG_STAGE_TWO_MS:    cfg_q.stage_two_ms    <= pwdata;
				taa_pkg::REG_STAGE_THREE_MS:  cfg_q.stage_three_ms  <= pwdata;
				taa_pkg::REG_PERIOD_ONE_MS:   cfg_q.period_one_ms   <= pwdata;
				taa_pkg::REG_PERIOD_TWO_MS:   cfg_q.period_two_ms   <= pwdata;
				taa_pkg::REG_PERIOD_THREE_MS: cfg_q.period_three_ms <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			taa_pkg::REG_SENSOR_ENABLE:   prdata = {31'd0, cfg_q.sensor_enable};
			taa_pkg::REG_LEVEL_THRESHOLD: prdata = {16'd0, cfg_q.level_threshold};
			taa_pkg::REG_STAGE_TWO_MS:    prdata = cfg_q.stage_two_ms;
			taa_pkg::REG_STAGE_THREE_MS:  prdata = cfg_q.stage_three_ms;
			taa_pkg::REG_PERIOD_ONE_MS:   prdata = cfg_q.period_one_ms;
			taa_pkg::REG_PERIOD_TWO_MS:   prdata = cfg_q.period_two_ms;
			taa_pkg::REG_PERIOD_THREE_MS: prdata = cfg_q.period_three_ms;
			default:                      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/taa_ring.sv
// Sample ring memory and running total: read at acceptance, update and write back as the word leaves s1.
`default_nettype none
module taa_ring #(
	parameter int WINDOW = taa_pkg::WINDOW_DEF,
	parameter int SUM_W  = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          tick_valid,
	input  wire logic [taa_pkg::SAMPLE_W-1:0]  touch_value,
	input  wire logic [taa_pkg::TIME_W-1:0]    now_ms,
	input  wire logic                          sensor_enable,
	output logic                               v_s2,
	output taa_pkg::tick_info_t                info_s2,
	output logic      [SUM_W-1:0]              sum_s2
);

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

	logic [taa_pkg::SAMPLE_W-1:0] ring_q [WINDOW];
	logic [WINDOW-1:0]            vld_q;
	logic [POS_W-1:0]             pos_q;
	logic [SUM_W-1:0]             sum_q;

	logic                         v_s1;
	logic                         en_s1;
	logic [POS_W-1:0]             pos_s1;
	logic [taa_pkg::SAMPLE_W-1:0] sample_s1;
	logic [taa_pkg::TIME_W-1:0]   now_s1;
	logic [taa_pkg::SAMPLE_W-1:0] rdata_s1;
	logic                         hit_s1;
	logic                         fwd_s1;
	logic [taa_pkg::SAMPLE_W-1:0] fwd_data_s1;

	logic                         acc;
	logic                         wr;
	logic [taa_pkg::SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]             sum_new;

	assign acc = tick_valid & adv;
	assign wr  = adv & v_s1 & en_s1;

	// An entry never written reads as zero; a write to the entry being read is forwarded.
	assign old_sample = fwd_s1 ? fwd_data_s1 : (hit_s1 ? rdata_s1 : '0);
	assign sum_new    = sum_q - SUM_W'(old_sample) + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			pos_q <= '0;
			sum_q <= '0;
			vld_q <= '0;
		end else if (adv) begin
			v_s1 <= tick_valid;
			v_s2 <= v_s1;
			if (acc && sensor_enable) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
			end
			if (v_s1 && en_s1) begin
				sum_q         <= sum_new;
				vld_q[pos_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			en_s1          <= sensor_enable;
			pos_s1         <= pos_q;
			sample_s1      <= touch_value;
			now_s1         <= now_ms;
			rdata_s1       <= ring_q[pos_q];
			hit_s1         <= vld_q[pos_q];
			fwd_s1         <= wr && (pos_s1 == pos_q);
			fwd_data_s1    <= sample_s1;
			info_s2.en     <= en_s1;
			info_s2.now_ms <= now_s1;
			sum_s2         <= en_s1 ? sum_new : sum_q;
		end
		if (wr) begin
			ring_q[pos_s1] <= sample_s1;
		end
	end

`ifndef SYNTHESIS
	// With more than one entry the write and the next read always hit different entries.
	a_fwd_only_single: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (WINDOW == 1))
		else $error("ring forwarding used with a multi-entry window");
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= LAST_POS))
		else $error("ring position beyond window");
`endif

endmodule
`default_nettype wire

### rtl/taa_avg.sv
// Average stage: running total divided by the window through a reciprocal multiply.
`default_nettype none
module taa_avg #(
	parameter int WINDOW = taa_pkg::WINDOW_DEF,
	parameter int SUM_W  = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          v_s2,
	input  wire taa_pkg::tick_info_t           info_s2,
	input  wire logic [SUM_W-1:0]              sum_s2,
	output logic                               v_s3,
	output taa_pkg::tick_info_t                info_s3,
	output logic      [taa_pkg::SAMPLE_W-1:0]  avg_s3
);

	// floor(n*M / 2^SHIFT) equals floor(n / WINDOW) for every n below 2^SUM_W.
	localparam int      SHIFT   = SUM_W + $clog2(WINDOW);
	localparam int      RECIP_W = SUM_W + 1;
	localparam int      PROD_W  = SUM_W + RECIP_W;
	localparam longint  RECIP_L = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
	                              / longint'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s3 <= info_s2;
			avg_s3  <= taa_pkg::SAMPLE_W'(prod >> SHIFT);
		end
	end

endmodule
`default_nettype wire

### rtl/taa_ctrl.sv
// Alarm state: arming, stage escalation, horn toggling and the result register.
`default_nettype none
module taa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          v_s3,
	input  wire taa_pkg::tick_info_t           info_s3,
	input  wire logic [taa_pkg::SAMPLE_W-1:0]  avg_s3,
	input  wire taa_pkg::cfg_t                 cfg,
	output logic                               result_valid,
	output logic                               horn_on,
	output logic      [1:0]                    alarm_stage,
	output logic                               unconscious,
	output logic      [taa_pkg::SAMPLE_W-1:0]  smoothed_level
);

	logic                         valid_q;
	logic                         armed_q;
	logic [taa_pkg::TIME_W-1:0]   arm_time_q;
	logic [taa_pkg::TIME_W-1:0]   toggle_time_q;
	taa_pkg::stage_t              stage_q;
	logic                         horn_q;
	logic                         unc_q;
	logic [taa_pkg::SAMPLE_W-1:0] level_q;

	logic                         armed_d;
	logic [taa_pkg::TIME_W-1:0]   arm_time_d;
	logic [taa_pkg::TIME_W-1:0]   toggle_time_d;
	taa_pkg::stage_t              stage_d;
	logic                         horn_d;
	logic                         unc_d;

	logic [taa_pkg::TIME_W-1:0]   base_arm;
	logic [taa_pkg::TIME_W-1:0]   base_toggle;
	taa_pkg::stage_t              base_stage;
	taa_pkg::stage_t              stage_esc;
	logic [taa_pkg::TIME_W-1:0]   elapsed;
	logic [taa_pkg::TIME_W-1:0]   since_toggle;
	logic                         toggle;

	always_comb begin
		// On the arming word both times restart at now, so both differences are zero.
		base_arm     = armed_q ? arm_time_q : info_s3.now_ms;
		base_toggle  = armed_q ? toggle_time_q : info_s3.now_ms;
		base_stage   = armed_q ? stage_q : taa_pkg::STAGE_SLOW;
		elapsed      = info_s3.now_ms - base_arm;
		since_toggle = info_s3.now_ms - base_toggle;

		if (elapsed >= cfg.stage_three_ms && base_stage != taa_pkg::STAGE_FAST) begin
			stage_esc = taa_pkg::STAGE_FAST;
		end else if (elapsed >= cfg.stage_two_ms && base_stage == taa_pkg::STAGE_SLOW) begin
			stage_esc = taa_pkg::STAGE_MEDIUM;
		end else begin
			stage_esc = base_stage;
		end

		unique case (stage_esc)
			taa_pkg::STAGE_FAST:   toggle = since_toggle >= cfg.period_three_ms;
			taa_pkg::STAGE_MEDIUM: toggle = since_toggle >= cfg.period_two_ms;
			default:               toggle = since_toggle >= cfg.period_one_ms;
		endcase

		armed_d       = armed_q;
		arm_time_d    = arm_time_q;
		toggle_time_d = toggle_time_q;
		stage_d       = stage_q;
		horn_d        = horn_q;
		unc_d         = unc_q;
		if (info_s3.en) begin
			if (avg_s3 > cfg.level_threshold) begin
				armed_d       = 1'b1;
				arm_time_d    = base_arm;
				toggle_time_d = toggle ? info_s3.now_ms : base_toggle;
				stage_d       = stage_esc;
				horn_d        = toggle ? ~horn_q : horn_q;
				unc_d         = unc_q | (stage_esc == taa_pkg::STAGE_FAST);
			end else begin
				armed_d = 1'b0;
				stage_d = taa_pkg::STAGE_IDLE;
				horn_d  = 1'b0;
				unc_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			armed_q       <= 1'b0;
			arm_time_q    <= '0;
			toggle_time_q <= '0;
			stage_q       <= taa_pkg::STAGE_IDLE;
			horn_q        <= 1'b0;
			unc_q         <= 1'b0;
		end else if (adv) begin
			valid_q <= v_s3;
			if (v_s3) begin
				armed_q       <= armed_d;
				arm_time_q    <= arm_time_d;
				toggle_time_q <= toggle_time_d;
				stage_q       <= stage_d;
				horn_q        <= horn_d;
				unc_q         <= unc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			level_q <= avg_s3;
		end
	end

	assign result_valid   = valid_q;
	assign horn_on        = horn_q;
	assign alarm_stage    = stage_q;
	assign unconscious    = unc_q;
	assign smoothed_level = level_q;

`ifndef SYNTHESIS
	a_unc_needs_fast: assert property (@(posedge clk) disable iff (!arst_n)
		unc_q |-> (stage_q == taa_pkg::STAGE_FAST))
		else $error("unconscious flag without fast stage");
	a_idle_horn_off: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == taa_pkg::STAGE_IDLE) |-> !horn_q)
		else $error("horn on while idle");
	a_armed_stage: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q == (stage_q != taa_pkg::STAGE_IDLE))
		else $error("armed flag and stage disagree");
	a_stage_no_fall: assert property (@(posedge clk) disable iff (!arst_n)
		($past(armed_q) && armed_q) |-> (stage_q >= $past(stage_q)))
		else $error("stage fell while armed");
`endif

endmodule
`default_nettype wire

### rtl/touch_alertness_alarm_top.sv
// Top level of the touch alertness alarm: register port, ring pipeline and alarm state.
//
// One tick word can be taken every clock cycle while tick_stall is low, and each produces
// exactly one result word; it passes the s1, s2 and s3 registers, then the result register.
// The ring of the last WINDOW readings sits in a memory with one read and one write port:
// it is read when a word is accepted and written when that word leaves s1, so a word can
// enter every cycle the pipeline moves. The average is the running total times a fixed
// reciprocal of WINDOW, and the alarm state updates once per word in the last stage. While
// result_stall holds a result, the whole pipeline freezes. tick_stall is high in exactly
// those cycles, and the block then holds at most four words. Ring entries start as zero
// through per-entry valid bits, so there is no clearing pass after reset.
`default_nettype none
module touch_alertness_alarm_top #(
	parameter int WINDOW = taa_pkg::WINDOW_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             tick_valid,
	output logic                                  tick_stall,
	input  wire logic [taa_pkg::SAMPLE_W-1:0]     touch_value,
	input  wire logic [taa_pkg::TIME_W-1:0]       now_ms,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic                                  horn_on,
	output logic      [1:0]                       alarm_stage,
	output logic                                  unconscious,
	output logic      [taa_pkg::SAMPLE_W-1:0]     smoothed_level,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [taa_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [taa_pkg::DATA_W-1:0]       pwdata,
	output logic      [taa_pkg::DATA_W-1:0]       prdata,
	output logic                                  pready
);

	localparam int SUM_W = $clog2(WINDOW * 65535 + 1);

	taa_pkg::cfg_t       cfg;
	taa_pkg::tick_info_t info_s2;
	taa_pkg::tick_info_t info_s3;
	logic                v_s2;
	logic                v_s3;
	logic [SUM_W-1:0]    sum_s2;
	logic [taa_pkg::SAMPLE_W-1:0] avg_s3;
	logic                adv;

	// The whole pipeline moves unless a finished word is held at the output.
	assign adv        = ~(result_valid & result_stall);
	assign tick_stall = ~adv;

	taa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	taa_ring #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.tick_valid    (tick_valid),
		.touch_value   (touch_value),
		.now_ms        (now_ms),
		.sensor_enable (cfg.sensor_enable),
		.v_s2          (v_s2),
		.info_s2       (info_s2),
		.sum_s2        (sum_s2)
	);

	taa_avg #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s2    (v_s2),
		.info_s2 (info_s2),
		.sum_s2  (sum_s2),
		.v_s3    (v_s3),
		.info_s3 (info_s3),
		.avg_s3  (avg_s3)
	);

	taa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.v_s3           (v_s3),
		.info_s3        (info_s3),
		.avg_s3         (avg_s3),
		.cfg            (cfg),
		.result_valid   (result_valid),
		.horn_on        (horn_on),
		.alarm_stage    (alarm_stage),
		.unconscious    (unconscious),
		.smoothed_level (smoothed_level)
	);

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the touch alertness alarm: directed tick table, then random ticks.
module tb;
	import taa_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam int N_PROBES = 25;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic        horn;
		stage_t      stage;
		logic        unc;
		logic [15:0] level;
	} alarm_word_t;

	typedef struct {
		logic [15:0] touch;
		logic [31:0] stamp;
		bit          typed;
		alarm_word_t word;
	} probe_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  tick_valid;
	logic                  tick_stall;
	logic [SAMPLE_W-1:0]   touch_value;
	logic [TIME_W-1:0]     now_ms;
	logic                  result_valid;
	logic                  result_stall;
	logic                  horn_on;
	logic [1:0]            alarm_stage;
	logic                  unconscious;
	logic [SAMPLE_W-1:0]   smoothed_level;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	touch_alertness_alarm_top u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the registers and of the alarm state.
	cfg_t        cfg_shadow;
	logic [15:0] ring [WIN];
	int          ring_pos;
	logic [31:0] level_sum;
	bit          is_armed;
	logic [31:0] armed_at;
	logic [31:0] toggled_at;
	stage_t      stage_q;
	bit          horn_q;
	bit          unc_q;

	alarm_word_t pending_words [$];
	probe_row_t  probe_rows [N_PROBES];
	int          fail_count = 0;
	int          burst_left = 0;
	int          hold_ask = 0;
	int          hold_done = 0;
	logic [31:0] clk_ms;

	function automatic void reset_alarm_model();
		cfg_shadow.sensor_enable   = RST_SENSOR_ENABLE;
		cfg_shadow.level_threshold = RST_LEVEL_THRESHOLD;
		cfg_shadow.stage_two_ms    = RST_STAGE_TWO_MS;
		cfg_shadow.stage_three_ms  = RST_STAGE_THREE_MS;
		cfg_shadow.period_one_ms   = RST_PERIOD_ONE_MS;
		cfg_shadow.period_two_ms   = RST_PERIOD_TWO_MS;
		cfg_shadow.period_three_ms = RST_PERIOD_THREE_MS;
		for (int i = 0; i < WIN; i++)
			ring[i] = '0;
		ring_pos   = 0;
		level_sum  = '0;
		is_armed   = 1'b0;
		armed_at   = '0;
		toggled_at = '0;
		stage_q    = STAGE_IDLE;
		horn_q     = 1'b0;
		unc_q      = 1'b0;
	endfunction

	function automatic void advance_alarm(input logic [15:0] touch, input logic [31:0] stamp,
			output alarm_word_t word);
		logic [15:0] avg;
		logic [31:0] since_arm;
		logic [31:0] period;
		if (cfg_shadow.sensor_enable) begin
			level_sum = level_sum - 32'(ring[ring_pos]) + 32'(touch);
			ring[ring_pos] = touch;
			ring_pos = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;
			avg = 16'(level_sum / WIN);
			if (avg > cfg_shadow.level_threshold) begin
				if (!is_armed) begin
					is_armed   = 1'b1;
					armed_at   = stamp;
					toggled_at = stamp;
					stage_q    = STAGE_SLOW;
				end
				since_arm = stamp - armed_at;
				// The stage only climbs while armed, whatever order the limits are in.
				if (since_arm >= cfg_shadow.stage_three_ms && stage_q != STAGE_FAST)
					stage_q = STAGE_FAST;
				else if (since_arm >= cfg_shadow.stage_two_ms && stage_q < STAGE_MEDIUM)
					stage_q = STAGE_MEDIUM;
				case (stage_q)
					STAGE_FAST:   period = cfg_shadow.period_three_ms;
					STAGE_MEDIUM: period = cfg_shadow.period_two_ms;
					default:      period = cfg_shadow.period_one_ms;
				endcase
				if (stamp - toggled_at >= period) begin
					horn_q     = !horn_q;
					toggled_at = stamp;
				end
				if (stage_q == STAGE_FAST)
					unc_q = 1'b1;
			end else begin
				horn_q   = 1'b0;
				is_armed = 1'b0;
				stage_q  = STAGE_IDLE;
				unc_q    = 1'b0;
			end
		end
		word.horn  = horn_q;
		word.stage = stage_q;
		word.unc   = unc_q;
		word.level = 16'(level_sum / WIN);
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		fail_count++;
	endfunction

	task automatic send_word(input logic [15:0] touch, input logic [31:0] stamp,
			input bit typed, input alarm_word_t typed_word);
		int gap;
		alarm_word_t predicted;
		if (burst_left == 0) begin
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = $urandom_range(1, 3);
				2:       gap = $urandom_range(1, 12);
				default: gap = $urandom_range(10, 40);
			endcase
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		tick_valid  <= 1'b1;
		touch_value <= touch;
		now_ms      <= stamp;
		do @(posedge clk); while (tick_stall);
		advance_alarm(touch, stamp, predicted);
		pending_words.push_back(typed ? typed_word : predicted);
		burst_left--;
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SENSOR_ENABLE:   cfg_shadow.sensor_enable   = val[0];
			REG_LEVEL_THRESHOLD: cfg_shadow.level_threshold = val[15:0];
			REG_STAGE_TWO_MS:    cfg_shadow.stage_two_ms    = val;
			REG_STAGE_THREE_MS:  cfg_shadow.stage_three_ms  = val;
			REG_PERIOD_ONE_MS:   cfg_shadow.period_one_ms   = val;
			REG_PERIOD_TWO_MS:   cfg_shadow.period_two_ms   = val;
			REG_PERIOD_THREE_MS: cfg_shadow.period_three_ms = val;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes every register plus the unused slot, then reads the seven registers back.
	task automatic program_regs(input logic en, input logic [15:0] thr, input logic [31:0] s2,
			input logic [31:0] s3, input logic [31:0] p1, input logic [31:0] p2,
			input logic [31:0] p3);
		logic [2:0]  idx;
		logic [31:0] want;
		logic [31:0] mask;
		logic [31:0] got;
		reg_write(REG_SENSOR_ENABLE, {31'd0, en});
		reg_write(REG_LEVEL_THRESHOLD, {16'd0, thr});
		reg_write(REG_STAGE_TWO_MS, s2);
		reg_write(REG_STAGE_THREE_MS, s3);
		reg_write(REG_PERIOD_ONE_MS, p1);
		reg_write(REG_PERIOD_TWO_MS, p2);
		reg_write(REG_PERIOD_THREE_MS, p3);
		reg_write(REG_UNUSED, $urandom());
		for (int i = 0; i < 7; i++) begin
			idx = i[2:0];
			mask = '1;
			case (idx)
				REG_SENSOR_ENABLE: begin
					want = {31'd0, cfg_shadow.sensor_enable};
					mask = 32'h1;
				end
				REG_LEVEL_THRESHOLD: begin
					want = {16'd0, cfg_shadow.level_threshold};
					mask = 32'hFFFF;
				end
				REG_STAGE_TWO_MS:   want = cfg_shadow.stage_two_ms;
				REG_STAGE_THREE_MS: want = cfg_shadow.stage_three_ms;
				REG_PERIOD_ONE_MS:  want = cfg_shadow.period_one_ms;
				REG_PERIOD_TWO_MS:  want = cfg_shadow.period_two_ms;
				default:            want = cfg_shadow.period_three_ms;
			endcase
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {idx, 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata & mask;
			psel    <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
			if (got !== want)
				note_mismatch($sformatf("register %0d readback", i), want, got);
		end
	endtask

	task automatic wait_drained();
		tick_valid <= 1'b0;
		burst_left = 0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly press and release stretches, so the alarm arms and climbs through its stages.
	task automatic run_random(input int count, input int hold_at, input int step_max);
		int seg_left;
		int mode;
		int r;
		logic [31:0] thr;
		logic [31:0] tv;
		seg_left = 0;
		mode = 0;
		for (int n = 0; n < count; n++) begin
			if (seg_left == 0) begin
				mode = $urandom_range(0, 9);
				seg_left = $urandom_range(3, 60);
			end
			seg_left--;
			thr = {16'd0, cfg_shadow.level_threshold};
			if (mode < 4) begin
				tv = thr + $urandom_range(1, 3000);
				if (tv > 32'hFFFF)
					tv = 32'hFFFF;
			end else if (mode < 7)
				tv = $urandom_range(0, thr);
			else if (mode < 8)
				tv = $urandom_range(0, 1) ? 32'hFFFF : 32'h0;
			else
				tv = $urandom();
			r = $urandom_range(0, 99);
			// A few ticks jump anywhere in time, and a few repeat the last timestamp.
			if (r < 3)
				clk_ms = $urandom();
			else if (r < 15)
				clk_ms += $urandom_range(0, 6000);
			else if (r >= 22)
				clk_ms += $urandom_range(1, step_max);
			send_word(tv[15:0], clk_ms, 1'b0, '0);
			if (n == hold_at)
				hold_ask++;
		end
	endtask

	initial begin : result_sink
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_done != hold_ask) begin
				// A long hold-off lets the block fill up and push back on the tick side.
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 150);
			end
			mode_left--;
			case (mode)
				0:       result_stall <= 1'b0;
				1:       result_stall <= ($urandom_range(0, 3) == 0);
				2:       result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= (mode_left % 4 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		alarm_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: result word expected none, got horn %0d stage %0d level %0d",
					$time, horn_on, alarm_stage, smoothed_level);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (horn_on !== want.horn)
					note_mismatch("horn_on", 32'(want.horn), 32'(horn_on));
				if (alarm_stage !== want.stage)
					note_mismatch("alarm_stage", 32'(want.stage), 32'(alarm_stage));
				if (unconscious !== want.unc)
					note_mismatch("unconscious", 32'(want.unc), 32'(unconscious));
				if (smoothed_level !== want.level)
					note_mismatch("smoothed_level", 32'(want.level), 32'(smoothed_level));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((tick_valid && !tick_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end while (quiet < QUIET_LIMIT);
		$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("** touch_alertness_alarm_top: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] thr;
		logic [31:0] s2;
		arst_n      = 1'b0;
		tick_valid  = 1'b0;
		touch_value = '0;
		now_ms      = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		clk_ms      = '0;
		reset_alarm_model();
		// Reset settings: arming, escalation, horn periods, time wrap and the threshold edge.
		probe_rows = '{
			'{16'd0,      32'd0,          1'b1, '{1'b0, STAGE_IDLE,   1'b0, 16'd0}},
			'{16'hFFFF,   32'd100,        1'b1, '{1'b0, STAGE_SLOW,   1'b0, 16'd6553}},
			'{16'hFFFF,   32'd1100,       1'b1, '{1'b1, STAGE_SLOW,   1'b0, 16'd13107}},
			'{16'd0,      32'd5100,       1'b1, '{1'b0, STAGE_MEDIUM, 1'b0, 16'd13107}},
			'{16'd0,      32'd10100,      1'b1, '{1'b1, STAGE_FAST,   1'b1, 16'd13107}},
			'{16'd0,      32'd10349,      1'b1, '{1'b1, STAGE_FAST,   1'b1, 16'd13107}},
			'{16'd0,      32'd10350,      1'b1, '{1'b0, STAGE_FAST,   1'b1, 16'd13107}},
			'{16'd0,      32'd10400,      1'b0, '0},
			'{16'd0,      32'd10500,      1'b0, '0},
			'{16'd0,      32'd10600,      1'b0, '0},
			'{16'd0,      32'd10700,      1'b0, '0},
			'{16'd0,      32'd10800,      1'b0, '0},
			'{16'd0,      32'd10900,      1'b1, '{1'b0, STAGE_IDLE,   1'b0, 16'd0}},
			'{16'hFFFF,   32'hFFFF_FF00,  1'b1, '{1'b0, STAGE_SLOW,   1'b0, 16'd6553}},
			'{16'd0,      32'd0,          1'b1, '{1'b0, STAGE_SLOW,   1'b0, 16'd6553}},
			'{16'd0,      32'd744,        1'b1, '{1'b1, STAGE_SLOW,   1'b0, 16'd6553}},
			'{16'd0,      32'd4744,       1'b1, '{1'b0, STAGE_MEDIUM, 1'b0, 16'd6553}},
			'{16'd0,      32'hFFFF_FFFF,  1'b1, '{1'b1, STAGE_MEDIUM, 1'b0, 16'd6553}},
			'{16'd0,      32'd100,        1'b0, '0},
			'{16'd0,      32'd200,        1'b0, '0},
			'{16'd0,      32'd300,        1'b0, '0},
			'{16'd0,      32'd400,        1'b0, '0},
			'{16'd0,      32'd500,        1'b0, '0},
			'{16'd209,    32'd600,        1'b1, '{1'b0, STAGE_IDLE,   1'b0, 16'd20}},
			'{16'd1,      32'd700,        1'b1, '{1'b0, STAGE_SLOW,   1'b0, 16'd21}}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_PROBES; k++)
			send_word(probe_rows[k].touch, probe_rows[k].stamp, probe_rows[k].typed,
				probe_rows[k].word);
		clk_ms = 32'd1000;
		run_random(180, 80, 400);

		// Zero threshold, zero limits and zero periods: straight to stage 3, horn every tick.
		wait_drained();
		program_regs(1'b1, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		run_random(180, -1, 400);

		// Top threshold can never be exceeded; all time values at their maximum.
		wait_drained();
		program_regs(1'b1, 16'hFFFF, '1, '1, '1, '1, '1);
		run_random(60, -1, 400);

		wait_drained();
		thr = 16'($urandom_range(50, 3000));
		program_regs(1'b1, thr, '1, '1, '1, '1, '1);
		run_random(180, -1, 400);

		// Sensor off: every word reports the held state.
		wait_drained();
		program_regs(1'b0, thr, 32'd2000, 32'd4000, 32'd300, 32'd200, 32'd100);
		run_random(60, -1, 400);

		// Stage limits out of order.
		wait_drained();
		s2 = $urandom_range(3000, 12000);
		program_regs(1'b1, 16'($urandom_range(0, 3000)), s2, $urandom_range(500, s2 - 1),
			$urandom_range(0, 1500), $urandom_range(0, 1500), $urandom_range(0, 1500));
		run_random(180, -1, 400);

		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			if (ph == 1)
				clk_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hF000);
			program_regs(1'b1, 16'($urandom_range(0, 2000)), $urandom_range(0, 20000),
				$urandom_range(0, 20000), $urandom_range(0, 2000), $urandom_range(0, 2000),
				$urandom_range(0, 2000));
			run_random(180, (ph == 0) ? 50 : -1, 300);
		end

		wait_drained();
		if (fail_count == 0)
			$display("** touch_alertness_alarm_top: PASSED **");
		else
			$display("** touch_alertness_alarm_top: FAILED **");
		$finish;
	end

endmodule
